FILE: hw/rtl/dst_pkg.sv
// dst_pkg: types, constants and the month table for the date span tracker
// no dependencies
package dst_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DNUM_W  = 22;
    localparam int Q100_W  = 7;
    localparam int PRIOR_W = 4;
    localparam int DBM_W   = 9;

    localparam logic [YEAR_W-1:0]  YEAR_MAX      = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_FIRST   = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST    = 4'd12;
    localparam logic [PRIOR_W-1:0] PRIOR_MAX     = 4'd12;
    localparam logic [PRIOR_W-1:0] PRIOR_MARCH   = 4'd2;
    localparam int                 RECIP100_W    = 13;
    localparam logic [RECIP100_W-1:0] RECIP100   = 13'd5243;
    localparam int                 RECIP100_SHIFT = 19;
    localparam logic [DNUM_W-1:0]  SPAN_MAX      = 22'd3652790;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [Q100_W-1:0]  q100;
        logic [PRIOR_W-1:0] prior;
        logic [DAY_W-1:0]   day;
        logic               last;
        logic               bad;
    } item_t;

    // days before the start of month prior+1 in a common year
    function automatic logic [DBM_W-1:0] days_before_month(input logic [PRIOR_W-1:0] prior);
        logic [DBM_W-1:0] d;
        unique case (prior)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd365;
        endcase
        return d;
    endfunction

endpackage

FILE: hw/rtl/dst_in_stage.sv
// dst_in_stage: input register, year saturation, month decode and year/100 by reciprocal
// depends on dst_pkg
module dst_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dst_pkg::YEAR_W-1:0]    s_year_in,
    input  logic [dst_pkg::MONTH_W-1:0]   s_month_in,
    input  logic [dst_pkg::DAY_W-1:0]     s_day_in,
    input  logic                          s_is_last,
    input  logic                          advance,
    output logic                          item_valid,
    output dst_pkg::item_t                item
);
    import dst_pkg::*;

    logic                             valid_reg;
    logic                             valid_next;
    item_t                            item_reg;
    item_t                            item_next;
    logic [YEAR_W-1:0]                year_sat;
    logic [YEAR_W+RECIP100_W-1:0]     prod;
    logic [MONTH_W-1:0]               month_m1;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        year_sat = (s_year_in > YEAR_MAX) ? YEAR_MAX : s_year_in;
        prod     = (YEAR_W+RECIP100_W)'(year_sat) * (YEAR_W+RECIP100_W)'(RECIP100);
        month_m1 = s_month_in - MONTH_FIRST;

        item_next.year = year_sat;
        item_next.q100 = prod[RECIP100_SHIFT +: Q100_W];
        if (s_month_in == '0) begin
            item_next.prior = '0;
        end else if (month_m1 > PRIOR_MAX) begin
            item_next.prior = PRIOR_MAX;
        end else begin
            item_next.prior = month_m1;
        end
        item_next.day  = s_day_in;
        item_next.last = s_is_last;
        item_next.bad  = (s_month_in < MONTH_FIRST) || (s_month_in > MONTH_LAST);

        valid_next = (s_valid && s_ready) || (valid_reg && !advance);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hw/rtl/dst_day_number.sv
// dst_day_number: closed-form Gregorian day number from a registered date item
// depends on dst_pkg
module dst_day_number (
    input  dst_pkg::item_t                item,
    output logic [dst_pkg::DNUM_W-1:0]    day_number
);
    import dst_pkg::*;

    logic [YEAR_W-1:0] q_times_100;
    logic [Q100_W-1:0] r100;
    logic              mod4z;
    logic              mod100z;
    logic              mod400z;
    logic              leap;
    logic [DNUM_W-1:0] ceil4;
    logic [DNUM_W-1:0] ceil100;
    logic [DNUM_W-1:0] ceil400;
    logic [DNUM_W-1:0] leaps;
    logic [DNUM_W-1:0] base;

    always_comb begin
        q_times_100 = YEAR_W'(item.q100) * YEAR_W'(100);
        r100        = Q100_W'(item.year - q_times_100);
        mod4z       = (item.year[1:0] == 2'd0);
        mod100z     = (r100 == '0);
        mod400z     = mod100z && (item.q100[1:0] == 2'd0);
        leap        = mod400z || (mod4z && !mod100z);

        ceil4   = (DNUM_W'(item.year) + DNUM_W'(3)) >> 2;
        ceil100 = DNUM_W'(item.q100) + DNUM_W'(!mod100z);
        ceil400 = DNUM_W'(item.q100 >> 2) + DNUM_W'(!mod400z);
        leaps   = ceil4 - ceil100 + ceil400;

        base       = DNUM_W'(item.year) * DNUM_W'(365);
        day_number = base + leaps
                   + DNUM_W'(days_before_month(item.prior))
                   + DNUM_W'((item.prior >= PRIOR_MARCH) && leap)
                   + DNUM_W'(item.day);
    end

endmodule

FILE: hw/rtl/date_span_tracker.sv
// date_span_tracker: top level, min/max tracking over a set of dates and the result register
// depends on dst_pkg, dst_in_stage, dst_day_number
//
// Takes one date per clock unless a held result stalls it, and keeps the smallest and
// largest Gregorian day number (counted from year 0, year 0 leap) of the current set.
// The date marked last gives one result: the span in days and a flag for any month
// outside 1 to 12; the tracker then starts a new set. A last date passes the input
// register, and its result is then registered in the result register; in the second
// stage the closed-form day number and the min/max compare are combinational. Years
// above 9999 are clamped; days are used unchecked.
module date_span_tracker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dst_pkg::YEAR_W-1:0]    s_year_in,
    input  logic [dst_pkg::MONTH_W-1:0]   s_month_in,
    input  logic [dst_pkg::DAY_W-1:0]     s_day_in,
    input  logic                          s_is_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dst_pkg::DNUM_W-1:0]    m_span_days,
    output logic                          m_bad_month
);
    import dst_pkg::*;

    logic              item_valid;
    item_t             item;
    logic              advance;
    logic [DNUM_W-1:0] dnum;

    logic              have_reg, have_next;
    logic              err_reg, err_next;
    logic [DNUM_W-1:0] min_reg, min_next;
    logic [DNUM_W-1:0] max_reg, max_next;
    logic              m_valid_reg, m_valid_next;
    logic [DNUM_W-1:0] span_reg, span_next;
    logic              bad_reg, bad_next;
    logic [DNUM_W-1:0] upd_min;
    logic [DNUM_W-1:0] upd_max;
    logic              upd_err;

    dst_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_year_in  (s_year_in),
        .s_month_in (s_month_in),
        .s_day_in   (s_day_in),
        .s_is_last  (s_is_last),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    dst_day_number u_day_number (
        .item       (item),
        .day_number (dnum)
    );

    assign advance = item_valid && (!m_valid_reg || m_ready);

    always_comb begin
        if (!have_reg) begin
            upd_min = dnum;
            upd_max = dnum;
        end else begin
            upd_min = (dnum < min_reg) ? dnum : min_reg;
            upd_max = (dnum > max_reg) ? dnum : max_reg;
        end
        upd_err = err_reg || item.bad;

        have_next    = have_reg;
        err_next     = err_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        span_next    = span_reg;
        bad_next     = bad_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (advance) begin
            if (item.last) begin
                have_next    = 1'b0;
                err_next     = 1'b0;
                min_next     = '0;
                max_next     = '0;
                span_next    = upd_max - upd_min;
                bad_next     = upd_err;
                m_valid_next = 1'b1;
            end else begin
                have_next = 1'b1;
                err_next  = upd_err;
                min_next  = upd_min;
                max_next  = upd_max;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg    <= 1'b0;
            err_reg     <= 1'b0;
            min_reg     <= '0;
            max_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            have_reg    <= have_next;
            err_reg     <= err_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        span_reg <= span_next;
        bad_reg  <= bad_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_span_days = span_reg;
    assign m_bad_month = bad_reg;

    // a new result only follows a last-of-set transaction in the second stage
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(advance && item.last))
        else $error("result without a last-of-set transaction");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item.last) |=> (!have_reg && !err_reg))
        else $error("set state not cleared after last transaction");

    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        have_reg |-> (min_reg <= max_reg))
        else $error("tracked minimum above maximum");

    a_span_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (span_reg <= SPAN_MAX))
        else $error("span out of range");

endmodule
